// File: hw/rtl/gda_pkg.sv
// Shared types, codes and calendar helpers for the Gregorian date block.
package gda_pkg;

    // Year range defaults
    localparam int DEF_MIN_YEAR = 1753;
    localparam int DEF_MAX_YEAR = 9999;

    // Held date after reset
    localparam logic [13:0] RESET_YEAR  = 14'd1970;
    localparam logic [3:0]  RESET_MONTH = 4'd1;
    localparam logic [4:0]  RESET_DAY   = 5'd1;

    // Item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_DAYS   = 2'd1;
    localparam logic [1:0] KIND_MONTHS = 2'd2;
    localparam logic [1:0] KIND_YEARS  = 2'd3;

    // Month codes used by the sequencer
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;
    localparam logic [4:0] DEC_LEN = 5'd31;

    // Constant divider operations of the shared unit
    localparam logic [1:0] DIV_OP_100 = 2'd0;
    localparam logic [1:0] DIV_OP_3   = 2'd1;
    localparam logic [1:0] DIV_OP_7   = 2'd2;

    // Month addition bias: keeps month index nonnegative before floor division by 12
    localparam int MON_BIAS_Q = 2731;
    localparam int MON_BIAS   = 12 * MON_BIAS_Q;

    localparam int DIV_W = 15;

    typedef struct packed {
        logic [1:0]       op;
        logic [DIV_W-1:0] a;
    } div_req_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic        rejected;
    } date_res_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
            len = 5'd30;
        else if (m == MON_FEB)
            len = leap ? 5'd29 : 5'd28;
        else
            len = 5'd31;
        return len;
    endfunction

    // floor(31 * m' / 12) with m' the March-based month index
    function automatic logic [4:0] wd_month_term(input logic [3:0] m);
        logic [4:0] t;
        case (m)
            4'd1:    t = 5'd28;
            4'd2:    t = 5'd31;
            4'd3:    t = 5'd2;
            4'd4:    t = 5'd5;
            4'd5:    t = 5'd7;
            4'd6:    t = 5'd10;
            4'd7:    t = 5'd12;
            4'd8:    t = 5'd15;
            4'd9:    t = 5'd18;
            4'd10:   t = 5'd20;
            4'd11:   t = 5'd23;
            4'd12:   t = 5'd25;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

// File: hw/rtl/gda_in_if.sv
// Command channel: one date operation per beat.
interface gda_in_if;
    import gda_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] amount;
    logic [13:0]        load_year;
    logic [3:0]         load_month;
    logic [4:0]         load_day;

    modport source (output valid, kind, amount, load_year, load_month, load_day,
                    input ready);
    modport sink   (input valid, kind, amount, load_year, load_month, load_day,
                    output ready);
endinterface

// File: hw/rtl/gda_out_if.sv
// Result channel: held date, weekday and reject flag per beat.
interface gda_out_if;
    import gda_pkg::*;

    logic        valid;
    logic        ready;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic        rejected;

    modport source (output valid, year, month, day, weekday, rejected, input ready);
    modport sink   (input valid, year, month, day, weekday, rejected, output ready);
endinterface

// File: hw/rtl/gda_cdiv.sv
// Shared constant divider: reciprocal multiply, quotient registered.
module gda_cdiv (
    input  logic                       clk,
    input  gda_pkg::div_req_t          req,
    output logic [gda_pkg::DIV_W-1:0]  q
);
    import gda_pkg::*;

    logic [DIV_W-1:0]   k;
    logic               sh19;
    logic [2*DIV_W-1:0] prod;
    logic [DIV_W-1:0]   q_next;
    logic [DIV_W-1:0]   q_reg;

    // Reciprocals exact over the operand ranges fed in
    always_comb
    begin
        case (req.op)
            DIV_OP_100:
            begin
                k    = 15'd5243;
                sh19 = 1'b1;
            end
            DIV_OP_3:
            begin
                k    = 15'd21846;
                sh19 = 1'b0;
            end
            DIV_OP_7:
            begin
                k    = 15'd9363;
                sh19 = 1'b0;
            end
            default:
            begin
                k    = '0;
                sh19 = 1'b0;
            end
        endcase
        prod   = (2*DIV_W)'(req.a) * (2*DIV_W)'(k);
        q_next = sh19 ? DIV_W'(prod[29:19]) : DIV_W'(prod[29:16]);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;
endmodule

// File: hw/rtl/gda_ctrl.sv
// Sequencer: held date, month walk and weekday steps over the shared divider.
module gda_ctrl #(
    parameter int MIN_YEAR = gda_pkg::DEF_MIN_YEAR,
    parameter int MAX_YEAR = gda_pkg::DEF_MAX_YEAR
) (
    input  logic                       clk,
    input  logic                       rst_n,
    gda_in_if.sink                     cmd,
    output gda_pkg::div_req_t          div_req,
    input  logic [gda_pkg::DIV_W-1:0]  div_q,
    output gda_pkg::date_res_t         done_res,
    output logic                       done_valid,
    input  logic                       done_take
);
    import gda_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LEAP_REQ = 4'd1;
    localparam logic [3:0] S_LEAP     = 4'd2;
    localparam logic [3:0] S_CHECK    = 4'd3;
    localparam logic [3:0] S_WALK     = 4'd4;
    localparam logic [3:0] S_MON_REQ  = 4'd5;
    localparam logic [3:0] S_MON      = 4'd6;
    localparam logic [3:0] S_WD_REQ   = 4'd7;
    localparam logic [3:0] S_WD_SUM   = 4'd8;
    localparam logic [3:0] S_WD_MREQ  = 4'd9;
    localparam logic [3:0] S_WD_MOD   = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0]         state_reg, state_next;
    logic [13:0]        cur_year_reg, cur_year_next;
    logic [3:0]         cur_month_reg, cur_month_next;
    logic [4:0]         cur_day_reg, cur_day_next;
    logic [13:0]        y_w_reg, y_w_next;
    logic [3:0]         m_w_reg, m_w_next;
    logic signed [16:0] d_w_reg, d_w_next;
    logic               leap_reg, leap_next;
    logic               walk_reg, walk_next;
    logic               load_reg, load_next;
    logic               rej_reg, rej_next;
    logic [16:0]        u_reg, u_next;
    logic [13:0]        yy_reg, yy_next;
    logic [13:0]        s_reg, s_next;
    logic [2:0]         wd_reg, wd_next;

    function automatic logic yr_ok(input logic signed [17:0] y);
        return (y >= $signed(18'(MIN_YEAR))) && (y <= $signed(18'(MAX_YEAR)));
    endfunction

    logic               load_ok;
    logic signed [16:0] day_sum;
    logic signed [17:0] yr_sum;
    logic signed [17:0] mon_t;
    logic signed [17:0] mon_y;
    logic [16:0]        mon_m;
    logic [21:0]        q100;
    logic [4:0]         len;
    logic [4:0]         prev_len;
    logic signed [16:0] len_s;
    logic               early;
    logic [13:0]        yy;
    logic [14:0]        wd_sum;
    logic [14:0]        wd_rem;

    always_comb
    begin
        load_ok = yr_ok($signed({4'd0, cmd.load_year})) &&
                  (cmd.load_month >= MON_JAN) && (cmd.load_month <= MON_DEC) &&
                  (cmd.load_day != 5'd0);
        day_sum = $signed({12'd0, cur_day_reg}) + $signed({cmd.amount[15], cmd.amount});
        yr_sum  = $signed({4'd0, cur_year_reg}) +
                  $signed({{2{cmd.amount[15]}}, cmd.amount});
        mon_t   = $signed({14'd0, cur_month_reg}) - 18'sd1 +
                  $signed({{2{cmd.amount[15]}}, cmd.amount}) + $signed(18'(MON_BIAS));
        mon_y   = $signed({4'd0, cur_year_reg}) + $signed({3'd0, div_q}) -
                  $signed(18'(MON_BIAS_Q));
        mon_m   = 17'(u_reg - 17'(div_q) * 17'd12 + 17'd1);
        q100    = 22'(div_q) * 22'd100;
        len      = month_len(m_w_reg, leap_reg);
        prev_len = month_len(4'(m_w_reg - 4'd1), leap_reg);
        len_s    = $signed({12'd0, len});
        // January and February count as months 11 and 12 of the year before
        early   = (cur_month_reg == MON_JAN) || (cur_month_reg == MON_FEB);
        yy      = cur_year_reg - {13'd0, early};
        wd_sum  = {10'd0, cur_day_reg} + {1'b0, yy_reg} + {3'd0, yy_reg[13:2]} -
                  div_q + {2'd0, div_q[14:2]} + {10'd0, wd_month_term(cur_month_reg)};
        wd_rem  = {1'b0, s_reg} - 15'(div_q * 15'd7);
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_year_next  = cur_year_reg;
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        y_w_next       = y_w_reg;
        m_w_next       = m_w_reg;
        d_w_next       = d_w_reg;
        leap_next      = leap_reg;
        walk_next      = walk_reg;
        load_next      = load_reg;
        rej_next       = rej_reg;
        u_next         = u_reg;
        yy_next        = yy_reg;
        s_next         = s_reg;
        wd_next        = wd_reg;
        div_req.op     = DIV_OP_100;
        div_req.a      = {1'b0, y_w_reg};
        done_valid     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    rej_next  = 1'b0;
                    walk_next = 1'b0;
                    load_next = 1'b0;
                    case (cmd.kind)
                        KIND_LOAD:
                        begin
                            if (load_ok)
                            begin
                                y_w_next   = cmd.load_year;
                                m_w_next   = cmd.load_month;
                                d_w_next   = $signed({12'd0, cmd.load_day});
                                load_next  = 1'b1;
                                state_next = S_LEAP_REQ;
                            end
                            else
                            begin
                                rej_next   = 1'b1;
                                state_next = S_WD_REQ;
                            end
                        end
                        KIND_DAYS:
                        begin
                            y_w_next   = cur_year_reg;
                            m_w_next   = cur_month_reg;
                            d_w_next   = day_sum;
                            walk_next  = 1'b1;
                            state_next = S_LEAP_REQ;
                        end
                        KIND_MONTHS:
                        begin
                            u_next     = mon_t[16:0];
                            state_next = S_MON_REQ;
                        end
                        KIND_YEARS:
                        begin
                            if (yr_ok(yr_sum))
                            begin
                                y_w_next   = yr_sum[13:0];
                                m_w_next   = cur_month_reg;
                                d_w_next   = $signed({12'd0, cur_day_reg});
                                state_next = S_LEAP_REQ;
                            end
                            else
                            begin
                                rej_next   = 1'b1;
                                state_next = S_WD_REQ;
                            end
                        end
                        default:
                        begin
                            rej_next   = 1'b1;
                            state_next = S_WD_REQ;
                        end
                    endcase
                end
            end
            S_MON_REQ:
            begin
                div_req.op = DIV_OP_3;
                div_req.a  = u_reg[16:2];
                state_next = S_MON;
            end
            S_MON:
            begin
                if (yr_ok(mon_y))
                begin
                    y_w_next   = mon_y[13:0];
                    m_w_next   = mon_m[3:0];
                    d_w_next   = $signed({12'd0, cur_day_reg});
                    state_next = S_LEAP_REQ;
                end
                else
                begin
                    rej_next   = 1'b1;
                    state_next = S_WD_REQ;
                end
            end
            S_LEAP_REQ:
            begin
                div_req.op = DIV_OP_100;
                div_req.a  = {1'b0, y_w_reg};
                state_next = S_LEAP;
            end
            S_LEAP:
            begin
                leap_next  = (y_w_reg[1:0] == 2'b00) &&
                             (({8'd0, y_w_reg} != q100) || (div_q[1:0] == 2'b00));
                state_next = walk_reg ? S_WALK : S_CHECK;
            end
            S_CHECK:
            begin
                if (load_reg && (d_w_reg > len_s))
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    cur_year_next  = y_w_reg;
                    cur_month_next = m_w_reg;
                    cur_day_next   = (d_w_reg > len_s) ? len : d_w_reg[4:0];
                end
                state_next = S_WD_REQ;
            end
            S_WALK:
            begin
                if (d_w_reg > len_s)
                begin
                    d_w_next = d_w_reg - len_s;
                    if (m_w_reg == MON_DEC)
                    begin
                        if (y_w_reg == 14'(MAX_YEAR))
                        begin
                            rej_next   = 1'b1;
                            state_next = S_WD_REQ;
                        end
                        else
                        begin
                            m_w_next   = MON_JAN;
                            y_w_next   = y_w_reg + 14'd1;
                            state_next = S_LEAP_REQ;
                        end
                    end
                    else
                    begin
                        m_w_next = m_w_reg + 4'd1;
                    end
                end
                else if (d_w_reg < 17'sd1)
                begin
                    if (m_w_reg == MON_JAN)
                    begin
                        if (y_w_reg == 14'(MIN_YEAR))
                        begin
                            rej_next   = 1'b1;
                            state_next = S_WD_REQ;
                        end
                        else
                        begin
                            m_w_next   = MON_DEC;
                            y_w_next   = y_w_reg - 14'd1;
                            d_w_next   = d_w_reg + $signed({12'd0, DEC_LEN});
                            state_next = S_LEAP_REQ;
                        end
                    end
                    else
                    begin
                        m_w_next = m_w_reg - 4'd1;
                        d_w_next = d_w_reg + $signed({12'd0, prev_len});
                    end
                end
                else
                begin
                    cur_year_next  = y_w_reg;
                    cur_month_next = m_w_reg;
                    cur_day_next   = d_w_reg[4:0];
                    state_next     = S_WD_REQ;
                end
            end
            S_WD_REQ:
            begin
                yy_next    = yy;
                div_req.op = DIV_OP_100;
                div_req.a  = {1'b0, yy};
                state_next = S_WD_SUM;
            end
            S_WD_SUM:
            begin
                s_next     = wd_sum[13:0];
                state_next = S_WD_MREQ;
            end
            S_WD_MREQ:
            begin
                div_req.op = DIV_OP_7;
                div_req.a  = {1'b0, s_reg};
                state_next = S_WD_MOD;
            end
            S_WD_MOD:
            begin
                wd_next    = wd_rem[2:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_valid = 1'b1;
                if (done_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_year_reg  <= RESET_YEAR;
            cur_month_reg <= RESET_MONTH;
            cur_day_reg   <= RESET_DAY;
            walk_reg      <= 1'b0;
            load_reg      <= 1'b0;
            rej_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_year_reg  <= cur_year_next;
            cur_month_reg <= cur_month_next;
            cur_day_reg   <= cur_day_next;
            walk_reg      <= walk_next;
            load_reg      <= load_next;
            rej_reg       <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_w_reg  <= y_w_next;
        m_w_reg  <= m_w_next;
        d_w_reg  <= d_w_next;
        leap_reg <= leap_next;
        u_reg    <= u_next;
        yy_reg   <= yy_next;
        s_reg    <= s_next;
        wd_reg   <= wd_next;
    end

    assign cmd.ready         = (state_reg == S_IDLE);
    assign done_res.year     = cur_year_reg;
    assign done_res.month    = cur_month_reg;
    assign done_res.day      = cur_day_reg;
    assign done_res.weekday  = wd_reg;
    assign done_res.rejected = rej_reg;
endmodule

// File: hw/rtl/gregorian_date_arithmetic.sv
// Top level of the Gregorian date block: sequencer, shared divider, result register.
//
//  channel  dir  beat contents
//  -------  ---  ------------------------------------------------------
//  cmd      in   kind, amount, load_year, load_month, load_day
//  res      out  year, month, day, weekday, rejected (one per cmd beat)
//
// Steps per command, from accept to result register loaded:
//   load and add years: leap test, date check, weekday; add months: /3 carry first;
//   add days: a month walk, with a new leap test at each year boundary crossed;
//   refused commands skip to the weekday steps. Every leap test, the month
//   carry and the weekday steps use the one shared divider in turn.
// Reset puts the held date at 1970-01-01; there is no clearing pass.
// cmd.ready is high only while the sequencer is idle. A finished result moves
//   into the output register; the next command is taken while it waits, and
//   the sequencer holds its next result until the register frees up.
module gregorian_date_arithmetic #(
    parameter int MIN_YEAR = gda_pkg::DEF_MIN_YEAR,
    parameter int MAX_YEAR = gda_pkg::DEF_MAX_YEAR
) (
    input  logic       clk,
    input  logic       rst_n,
    gda_in_if.sink     cmd,
    gda_out_if.source  res
);
    import gda_pkg::*;

    div_req_t         div_req;
    logic [DIV_W-1:0] div_q;
    date_res_t        done_res;
    logic             done_valid;
    logic             done_take;

    logic             out_valid_reg, out_valid_next;
    date_res_t        out_reg, out_next;

    gda_ctrl #(
        .MIN_YEAR (MIN_YEAR),
        .MAX_YEAR (MAX_YEAR)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .div_req    (div_req),
        .div_q      (div_q),
        .done_res   (done_res),
        .done_valid (done_valid),
        .done_take  (done_take)
    );

    // One multiplier serves /100 (leap and weekday), /3 (month carry), /7 (weekday)
    gda_cdiv u_cdiv (
        .clk (clk),
        .req (div_req),
        .q   (div_q)
    );

    // Result register: loads when empty or being drained this cycle
    always_comb
    begin
        done_take      = done_valid && (!out_valid_reg || res.ready);
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (done_take)
        begin
            out_valid_next = 1'b1;
            out_next       = done_res;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res.valid    = out_valid_reg;
    assign res.year     = out_reg.year;
    assign res.month    = out_reg.month;
    assign res.day      = out_reg.day;
    assign res.weekday  = out_reg.weekday;
    assign res.rejected = out_reg.rejected;

    // A beat handed over by the sequencer shows up at the output next cycle
    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        done_take |=> res.valid)
        else $error("result handed over but output not valid");

    // Sequencer is never idle while it still holds a result
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !done_valid)
        else $error("ready while a result is pending");

    // Held date stays inside the calendar and year range
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.year >= 14'(MIN_YEAR)) && (res.year <= 14'(MAX_YEAR)) &&
                      (res.month >= MON_JAN) && (res.month <= MON_DEC) &&
                      (res.day != 5'd0) &&
                      (res.day <= month_len(res.month, 1'b1)))
        else $error("output date out of range");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.weekday <= 3'd6))
        else $error("weekday out of range");
endmodule

// File: dv/tb.sv
// Self-checking testbench for the Gregorian date block: directed plan, random beats, scoreboard.
module tb;
    import gda_pkg::*;

    // One command beat as the driver sees it.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] amount;
        logic [13:0]        load_year;
        logic [3:0]         load_month;
        logic [4:0]         load_day;
    } cmd_beat_t;

    // Directed plan row: typed rows carry a hand-computed result, the rest use the date model.
    typedef struct {
        cmd_beat_t beat;
        bit        typed;
        date_res_t want;
    } plan_row_t;

    localparam int MIN_YR      = DEF_MIN_YEAR;
    localparam int MAX_YR      = DEF_MAX_YEAR;
    localparam int RANDOM_CMDS = 500;
    // Longer than the worst day walk; give stray results that long to show up.
    localparam int DRAIN_CYCLES = 1400;

    logic clk = 1'b0;
    logic rst_n;

    gda_in_if  cmd_ch ();
    gda_out_if res_ch ();

    gregorian_date_arithmetic dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Date model state: mirrors the held date in the block.
    int held_year  = RESET_YEAR;
    int held_month = RESET_MONTH;
    int held_day   = RESET_DAY;

    date_res_t expected_dates[$];
    plan_row_t directed_plan[$];
    int        mismatches   = 0;
    int        send_steady  = 0;
    int        recv_steady  = 0;
    int        recv_hold    = 0;

    // ------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------
    function automatic bit greg_leap(input int y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int month_days(input int m, input int y);
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        if (m == 2)
            return greg_leap(y) ? 29 : 28;
        return 31;
    endfunction

    // Zeller-style sum with the year starting in March; 0 is Sunday.
    function automatic int day_of_week(input int y0, input int m0, input int d);
        int a;
        int y;
        int m;
        a = (14 - m0) / 12;
        y = y0 - a;
        m = m0 + 12 * a - 2;
        return (d + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12) % 7;
    endfunction

    function automatic bit year_in_range(input int y);
        return y >= MIN_YR && y <= MAX_YR;
    endfunction

    // Applies one command to the held date and returns the result beat it produces.
    function automatic date_res_t advance_date(input cmd_beat_t c);
        int        y;
        int        m;
        int        d;
        int        amt;
        int        t;
        int        q;
        int        ly;
        int        lm;
        int        ld;
        bit        ok;
        date_res_t r;
        y   = held_year;
        m   = held_month;
        d   = held_day;
        amt = c.amount;
        ly  = c.load_year;
        lm  = c.load_month;
        ld  = c.load_day;
        ok  = 1'b1;
        case (c.kind)
            KIND_LOAD:
            begin
                ok = year_in_range(ly) && lm >= 1 && lm <= 12 && ld >= 1 &&
                     ld <= month_days(lm, ly);
                if (ok)
                begin
                    y = ly;
                    m = lm;
                    d = ld;
                end
            end
            KIND_DAYS:
            begin
                // Month-by-month walk; any year crossed out of range kills the whole step.
                d = d + amt;
                while (ok && d > month_days(m, y))
                begin
                    d = d - month_days(m, y);
                    m = m + 1;
                    if (m > 12)
                    begin
                        m = 1;
                        y = y + 1;
                        ok = year_in_range(y);
                    end
                end
                while (ok && d < 1)
                begin
                    m = m - 1;
                    if (m < 1)
                    begin
                        m = 12;
                        y = y - 1;
                        ok = year_in_range(y);
                    end
                    if (ok)
                        d = d + month_days(m, y);
                end
            end
            KIND_MONTHS:
            begin
                // Floor division by 12 for negative month offsets.
                t = m - 1 + amt;
                q = (t >= 0) ? t / 12 : -((-t + 11) / 12);
                y = y + q;
                m = t - 12 * q + 1;
                ok = year_in_range(y);
                if (ok && d > month_days(m, y))
                    d = month_days(m, y);
            end
            KIND_YEARS:
            begin
                y = y + amt;
                ok = year_in_range(y);
                if (ok && m == 2 && d == 29 && !greg_leap(y))
                    d = 28;
            end
        endcase
        if (ok)
        begin
            held_year  = y;
            held_month = m;
            held_day   = d;
        end
        r.year     = 14'(held_year);
        r.month    = 4'(held_month);
        r.day      = 5'(held_day);
        r.weekday  = 3'(day_of_week(held_year, held_month, held_day));
        r.rejected = !ok;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed plan helpers
    // ------------------------------------------------------------------
    function automatic cmd_beat_t make_cmd(input logic [1:0] k, input int amt, input int ly,
                                           input int lm, input int ld);
        cmd_beat_t b;
        b.kind       = k;
        b.amount     = 16'(amt);
        b.load_year  = 14'(ly);
        b.load_month = 4'(lm);
        b.load_day   = 5'(ld);
        return b;
    endfunction

    task automatic plan_step(input logic [1:0] k, input int amt, input int ly, input int lm,
                             input int ld);
        plan_row_t row;
        row.beat  = make_cmd(k, amt, ly, lm, ld);
        row.typed = 1'b0;
        row.want  = '0;
        directed_plan.push_back(row);
    endtask

    task automatic plan_known(input logic [1:0] k, input int amt, input int ly, input int lm,
                              input int ld, input int ey, input int em, input int ed,
                              input int ewd, input bit erej);
        plan_row_t row;
        row.beat           = make_cmd(k, amt, ly, lm, ld);
        row.typed          = 1'b1;
        row.want.year      = 14'(ey);
        row.want.month     = 4'(em);
        row.want.day       = 5'(ed);
        row.want.weekday   = 3'(ewd);
        row.want.rejected  = erej;
        directed_plan.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------
    // Mostly well-formed loads and moderate offsets; a share of full-range noise.
    function automatic cmd_beat_t random_beat();
        cmd_beat_t b;
        int        pick;
        int        v;
        int        y;
        int        m;
        pick         = $urandom_range(0, 99);
        v            = $urandom_range(0, 19);
        b.kind       = KIND_DAYS;
        b.amount     = 16'($urandom);
        b.load_year  = 14'($urandom);
        b.load_month = 4'($urandom);
        b.load_day   = 5'($urandom);
        if (pick < 25)
        begin
            b.kind = KIND_LOAD;
            if (v < 17)
            begin
                if (v < 4)
                    y = $urandom_range(MIN_YR, MIN_YR + 40);
                else if (v < 8)
                    y = $urandom_range(MAX_YR - 40, MAX_YR);
                else
                    y = $urandom_range(MIN_YR, MAX_YR);
                m = $urandom_range(1, 12);
                b.load_year  = 14'(y);
                b.load_month = 4'(m);
                b.load_day   = 5'($urandom_range(1, month_days(m, y)));
            end
        end
        else if (pick < 55)
        begin
            b.kind = KIND_DAYS;
            // full-range day counts are slow, keep them rare
            if (v < 16)
                b.amount = 16'(int'($urandom_range(0, 800)) - 400);
            else if (v < 19)
                b.amount = 16'(int'($urandom_range(0, 40000)) - 20000);
        end
        else if (pick < 78)
        begin
            b.kind = KIND_MONTHS;
            if (v < 17)
                b.amount = 16'(int'($urandom_range(0, 600)) - 300);
        end
        else
        begin
            b.kind = KIND_YEARS;
            if (v < 17)
                b.amount = 16'(int'($urandom_range(0, 600)) - 300);
        end
        return b;
    endfunction

    // Sender gap: mostly none or short, a few long, with gap-free bursts.
    function automatic int sender_gap();
        int r;
        if (send_steady > 0)
        begin
            send_steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            send_steady = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drives one command beat, holds it until accepted, then queues its result.
    task automatic send_beat(input cmd_beat_t b, input bit typed, input date_res_t want);
        int        gap;
        date_res_t modeled;
        gap = sender_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.kind       <= b.kind;
        cmd_ch.amount     <= b.amount;
        cmd_ch.load_year  <= b.load_year;
        cmd_ch.load_month <= b.load_month;
        cmd_ch.load_day   <= b.load_day;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        // Model always runs so the held date tracks typed rows too.
        modeled = advance_date(b);
        expected_dates.push_back(typed ? want : modeled);
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and scoreboard
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : recv_side
        int r;
        if (recv_hold > 0)
        begin
            recv_hold--;
            res_ch.ready <= 1'b0;
        end
        else if (recv_steady > 0)
        begin
            recv_steady--;
            res_ch.ready <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                recv_steady = $urandom_range(20, 80);
                res_ch.ready <= 1'b1;
            end
            else if (r < 70)
                res_ch.ready <= 1'b1;
            else if (r < 94)
            begin
                recv_hold = $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end
            else
            begin
                recv_hold = $urandom_range(10, 50);
                res_ch.ready <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        date_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_dates.size() == 0)
            begin
                $display("%0t: unexpected result beat %0d-%0d-%0d wd %0d rej %0d", $time,
                         res_ch.year, res_ch.month, res_ch.day, res_ch.weekday,
                         res_ch.rejected);
                mismatches++;
            end
            else
            begin
                want = expected_dates.pop_front();
                check_field("year", want.year, res_ch.year);
                check_field("month", want.month, res_ch.month);
                check_field("day", want.day, res_ch.day);
                check_field("weekday", want.weekday, res_ch.weekday);
                check_field("rejected", want.rejected, res_ch.rejected);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.kind       = KIND_LOAD;
        cmd_ch.amount     = '0;
        cmd_ch.load_year  = '0;
        cmd_ch.load_month = '0;
        cmd_ch.load_day   = '0;
        res_ch.ready      = 1'b0;

        // Directed plan. Reset date 1970-01-01 is a Thursday.
        plan_known(KIND_DAYS,   0,     0,     0,  0,  1970, 1,  1,  4, 1'b0);
        // Top of range: 9999-12-31 is a Friday, every step forward is refused.
        plan_known(KIND_LOAD,   0,     9999,  12, 31, 9999, 12, 31, 5, 1'b0);
        plan_known(KIND_DAYS,   1,     0,     0,  0,  9999, 12, 31, 5, 1'b1);
        plan_known(KIND_MONTHS, 1,     0,     0,  0,  9999, 12, 31, 5, 1'b1);
        plan_known(KIND_YEARS,  1,     0,     0,  0,  9999, 12, 31, 5, 1'b1);
        // Bottom of range: 1753-01-01 is a Monday, each step back driven here is refused.
        plan_known(KIND_LOAD,   0,     1753,  1,  1,  1753, 1,  1,  1, 1'b0);
        plan_known(KIND_DAYS,   -1,    0,     0,  0,  1753, 1,  1,  1, 1'b1);
        plan_known(KIND_YEARS,  -1,    0,     0,  0,  1753, 1,  1,  1, 1'b1);
        // Bad loads keep the held date.
        plan_known(KIND_LOAD,   0,     1752,  12, 31, 1753, 1,  1,  1, 1'b1);
        plan_known(KIND_LOAD,   0,     16383, 1,  1,  1753, 1,  1,  1, 1'b1);
        plan_known(KIND_LOAD,   0,     2000,  0,  1,  1753, 1,  1,  1, 1'b1);
        plan_known(KIND_LOAD,   0,     2000,  15, 1,  1753, 1,  1,  1, 1'b1);
        plan_known(KIND_LOAD,   0,     2000,  1,  0,  1753, 1,  1,  1, 1'b1);
        plan_known(KIND_LOAD,   0,     2001,  4,  31, 1753, 1,  1,  1, 1'b1);
        plan_step(KIND_LOAD,    0,     2000,  1,  31);
        // 1900 is not leap (century rule); held date stays 2000-01-31, a Monday.
        plan_known(KIND_LOAD,   0,     1900,  2,  29, 2000, 1,  31, 1, 1'b1);
        // Leap-day handling: 400-year leap, year add rounds Feb 29 down, month clamp.
        plan_step(KIND_LOAD,    0,     2000,  2,  29);
        plan_step(KIND_YEARS,   1,     0,     0,  0);
        plan_step(KIND_LOAD,    0,     2024,  1,  31);
        plan_step(KIND_MONTHS,  1,     0,     0,  0);
        plan_step(KIND_YEARS,   76,    0,     0,  0);
        // Extreme offsets, zero offsets.
        plan_step(KIND_MONTHS,  32767, 0,     0,  0);
        plan_step(KIND_MONTHS,  -32768, 0,    0,  0);
        plan_step(KIND_DAYS,    32767, 0,     0,  0);
        plan_step(KIND_DAYS,    -32768, 0,    0,  0);
        plan_step(KIND_YEARS,   -32768, 0,    0,  0);
        plan_step(KIND_MONTHS,  0,     0,     0,  0);
        plan_step(KIND_YEARS,   0,     0,     0,  0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
            send_beat(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].want);

        repeat (RANDOM_CMDS)
            send_beat(random_beat(), 1'b0, '0);

        cmd_ch.valid <= 1'b0;

        // Drain, then leave room for any stray beat.
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog: ~530 beats at worst-case walk plus long stalls, with wide margin.
    initial
    begin
        #40_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
